// ----- sv/b64ld_pkg.sv -----
// Package for the base64 line decoder: sizes, character codes, result kinds,
// sequencer states and the base64 alphabet lookup.
// Depends on nothing; used by base64_line_decoder_core.
`default_nettype none

package b64ld_pkg;

	// Longest line body, in characters.
	localparam int LINE_CHARS = 76;
	// The line counter must hold LINE_CHARS itself.
	localparam int CNT_W  = $clog2(LINE_CHARS + 1);
	localparam int ADDR_W = $clog2(LINE_CHARS);

	localparam logic [7:0] ASCII_NUL = 8'h00;
	localparam logic [7:0] ASCII_NL  = 8'h0A;
	localparam logic [7:0] ASCII_CR  = 8'h0D;
	localparam logic [7:0] ASCII_PAD = 8'h3D;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_CHECK,
		S_READ,
		S_EVAL,
		S_EMIT,
		S_FINAL
	} seq_state_t;

	// Returns {valid, value} for one character of the standard alphabet.
	function automatic logic [6:0] sextet(input logic [7:0] ch);
		logic [6:0] r;
		r = '0;
		if (ch >= 8'h41 && ch <= 8'h5A) begin
			r = {1'b1, 6'(ch - 8'h41)};
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
		end else if (ch == 8'h2B) begin
			r = {1'b1, 6'd62};
		end else if (ch == 8'h2F) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/base64_line_decoder_core.sv -----
// Top level of the base64 line decoder: line memory, quad sequencer and
// output register. Depends on b64ld_pkg.
`default_nettype none

// Usage
// The input channel (in_valid, in_stall, text_byte, end_of_input) carries
// one body character per transaction. Ordinary characters are written into
// a 76-entry line memory; a character that follows a held-back carriage
// return passes through the PUSH state, since both go into the memory.
// A newline, or an end-of-input transaction while a line is pending,
// starts the line check. The sequencer then reads each quad of the line
// from the memory through the single read port with its registered data,
// checks it in the EVAL state, and hands its one to three bytes to the
// output register one per cycle while the receiver does not stall.
// The input is stalled for the whole line check. The output channel
// (out_valid, out_stall, data_byte, kind, last) is a single register; when
// the receiver stalls it, the sequencer simply waits, and nothing is lost.
// A success or error result ends the stream: further transactions are
// accepted and dropped. Reset clears the line counter, the flags and the
// halt flag; the line memory is not cleared, since only entries written on
// the current line are ever read.
module base64_line_decoder_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic [7:0]           text_byte,
	input  wire logic                 end_of_input,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic [7:0]           data_byte,
	output      logic [1:0]           kind,
	output      logic                 last
);

	b64ld_pkg::seq_state_t state_q, state_next;

	logic [b64ld_pkg::CNT_W-1:0] count_q;
	logic overlong_q, pending_q, zero_q, halted_q, eoi_q;
	logic [7:0] held_q;

	logic [b64ld_pkg::CNT_W-1:0] base_q;
	logic [2:0] phase_q;
	logic [7:0] rdata_s1;
	logic [7:0] quad_q [4];

	logic [7:0] bytes_q [3];
	logic [1:0] nb_q, idx_q;
	logic lastq_q;
	b64ld_pkg::kind_t final_kind_q;

	logic out_valid_q, last_q;
	logic [7:0] data_q;
	b64ld_pkg::kind_t kind_q;

	logic [7:0] line_mem [b64ld_pkg::LINE_CHARS];

	// Handshake and decoded input.
	logic accept, out_free, line_pending, is_nl;
	assign in_stall     = (state_q != b64ld_pkg::S_IDLE);
	assign accept       = in_valid && !in_stall;
	assign out_free     = !out_valid_q || !out_stall;
	assign is_nl        = (text_byte == b64ld_pkg::ASCII_NL);
	assign line_pending = (count_q != '0) || overlong_q || pending_q || zero_q;

	// An ordinary character is taken only when it still counts as content.
	logic take_char;
	assign take_char = accept && !halted_q && !end_of_input && !is_nl && !zero_q;

	// Quad evaluation, from the four characters just read.
	logic [6:0] sa, sb, sc, sd;
	logic c_pad, d_pad, quad_err, quad_term, quad_last;
	always_comb begin
		sa = b64ld_pkg::sextet(quad_q[0]);
		sb = b64ld_pkg::sextet(quad_q[1]);
		sc = b64ld_pkg::sextet(quad_q[2]);
		sd = b64ld_pkg::sextet(quad_q[3]);
		c_pad = (quad_q[2] == b64ld_pkg::ASCII_PAD);
		d_pad = (quad_q[3] == b64ld_pkg::ASCII_PAD);
		quad_last = ((base_q + b64ld_pkg::CNT_W'(4)) == count_q);
		// The terminator line is exactly four padding characters.
		quad_term = (count_q == b64ld_pkg::CNT_W'(4))
			&& (quad_q[0] == b64ld_pkg::ASCII_PAD) && (quad_q[1] == b64ld_pkg::ASCII_PAD)
			&& c_pad && d_pad;
		quad_err = !sa[6] || !sb[6] || (!c_pad && !sc[6]) || (!d_pad && !sd[6])
			|| (c_pad && !d_pad)
			|| (c_pad && (sb[3:0] != 4'd0))
			|| (d_pad && !c_pad && (sc[1:0] != 2'd0))
			|| ((c_pad || d_pad) && !quad_last);
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			b64ld_pkg::S_IDLE: begin
				if (accept && !halted_q) begin
					if (end_of_input) begin
						state_next = line_pending ? b64ld_pkg::S_CHECK : b64ld_pkg::S_FINAL;
					end else if (is_nl) begin
						state_next = b64ld_pkg::S_CHECK;
					end else if (!zero_q && pending_q && text_byte != b64ld_pkg::ASCII_CR
						&& text_byte != b64ld_pkg::ASCII_NUL) begin
						state_next = b64ld_pkg::S_PUSH;
					end
				end
			end
			b64ld_pkg::S_PUSH: begin
				state_next = b64ld_pkg::S_IDLE;
			end
			b64ld_pkg::S_CHECK: begin
				if (overlong_q || count_q == '0 || count_q[1:0] != 2'd0) begin
					state_next = b64ld_pkg::S_FINAL;
				end else begin
					state_next = b64ld_pkg::S_READ;
				end
			end
			b64ld_pkg::S_READ: begin
				if (phase_q == 3'd4) begin
					state_next = b64ld_pkg::S_EVAL;
				end
			end
			b64ld_pkg::S_EVAL: begin
				state_next = (quad_term || quad_err) ? b64ld_pkg::S_FINAL : b64ld_pkg::S_EMIT;
			end
			b64ld_pkg::S_EMIT: begin
				if (out_free && idx_q == nb_q - 2'd1) begin
					if (!lastq_q) begin
						state_next = b64ld_pkg::S_READ;
					end else if (eoi_q) begin
						state_next = b64ld_pkg::S_FINAL;
					end else begin
						state_next = b64ld_pkg::S_IDLE;
					end
				end
			end
			b64ld_pkg::S_FINAL: begin
				if (out_free) begin
					state_next = b64ld_pkg::S_IDLE;
				end
			end
			default: state_next = b64ld_pkg::S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	logic push_req, push_en, emit_en, emit_last, line_clear, set_halt;
	logic [7:0] push_data, emit_byte;
	b64ld_pkg::kind_t emit_kind;
	always_comb begin
		push_req   = 1'b0;
		push_data  = text_byte;
		emit_en    = 1'b0;
		emit_kind  = b64ld_pkg::KIND_DATA;
		emit_byte  = bytes_q[idx_q];
		emit_last  = 1'b0;
		line_clear = 1'b0;
		set_halt   = 1'b0;
		unique case (state_q)
			b64ld_pkg::S_IDLE: begin
				// A held-back carriage return becomes content first.
				if (take_char && pending_q) begin
					push_req  = 1'b1;
					push_data = b64ld_pkg::ASCII_CR;
				end else if (take_char && text_byte != b64ld_pkg::ASCII_CR
					&& text_byte != b64ld_pkg::ASCII_NUL) begin
					push_req = 1'b1;
				end
			end
			b64ld_pkg::S_PUSH: begin
				push_req  = 1'b1;
				push_data = held_q;
			end
			b64ld_pkg::S_EMIT: begin
				emit_en   = out_free;
				emit_last = (idx_q == nb_q - 2'd1) && lastq_q && !eoi_q;
				line_clear = out_free && (idx_q == nb_q - 2'd1) && lastq_q;
			end
			b64ld_pkg::S_FINAL: begin
				emit_en    = out_free;
				emit_kind  = final_kind_q;
				emit_byte  = 8'd0;
				emit_last  = 1'b1;
				line_clear = out_free;
				set_halt   = out_free;
			end
			default: begin
			end
		endcase
		push_en = push_req && (count_q < b64ld_pkg::CNT_W'(b64ld_pkg::LINE_CHARS));
	end

	// Line memory: one write port, one read port with registered data.
	logic [b64ld_pkg::ADDR_W-1:0] rd_addr;
	assign rd_addr = b64ld_pkg::ADDR_W'(base_q + b64ld_pkg::CNT_W'(phase_q));

	always_ff @(posedge clk) begin
		if (push_en) begin
			line_mem[count_q[b64ld_pkg::ADDR_W-1:0]] <= push_data;
		end
		rdata_s1 <= line_mem[rd_addr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= b64ld_pkg::S_IDLE;
			count_q     <= '0;
			overlong_q  <= 1'b0;
			pending_q   <= 1'b0;
			zero_q      <= 1'b0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (push_en) begin
				count_q <= count_q + b64ld_pkg::CNT_W'(1);
			end else if (push_req) begin
				overlong_q <= 1'b1;
			end
			if (take_char) begin
				pending_q <= (text_byte == b64ld_pkg::ASCII_CR);
				if (text_byte == b64ld_pkg::ASCII_NUL) begin
					zero_q <= 1'b1;
				end
			end
			if (line_clear) begin
				count_q    <= '0;
				overlong_q <= 1'b0;
				pending_q  <= 1'b0;
				zero_q     <= 1'b0;
			end
			if (set_halt) begin
				halted_q <= 1'b1;
			end
			if (out_free) begin
				out_valid_q <= emit_en;
			end
		end
	end

	// Datapath registers of the sequencer and the output register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			b64ld_pkg::S_IDLE: begin
				held_q  <= text_byte;
				eoi_q   <= end_of_input;
				final_kind_q <= b64ld_pkg::KIND_ERROR;
			end
			b64ld_pkg::S_CHECK: begin
				base_q  <= '0;
				phase_q <= 3'd0;
				idx_q   <= 2'd0;
			end
			b64ld_pkg::S_READ: begin
				phase_q <= phase_q + 3'd1;
				if (phase_q != 3'd0) begin
					quad_q[2'(phase_q - 3'd1)] <= rdata_s1;
				end
			end
			b64ld_pkg::S_EVAL: begin
				bytes_q[0] <= {sa[5:0], sb[5:4]};
				bytes_q[1] <= {sb[3:0], sc[5:2]};
				bytes_q[2] <= {sc[1:0], sd[5:0]};
				nb_q    <= c_pad ? 2'd1 : (d_pad ? 2'd2 : 2'd3);
				lastq_q <= quad_last;
				final_kind_q <= quad_term ? b64ld_pkg::KIND_DONE : b64ld_pkg::KIND_ERROR;
			end
			b64ld_pkg::S_EMIT: begin
				if (out_free) begin
					if (idx_q == nb_q - 2'd1) begin
						idx_q   <= 2'd0;
						base_q  <= base_q + b64ld_pkg::CNT_W'(4);
						phase_q <= 3'd0;
						final_kind_q <= b64ld_pkg::KIND_ERROR;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
			end
			default: begin
			end
		endcase
		if (emit_en) begin
			data_q <= emit_byte;
			kind_q <= emit_kind;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = data_q;
	assign kind      = kind_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ----- tb/sv/base64_line_decoder_core_tb.sv -----
// Self-checking testbench for base64_line_decoder_core: a directed table of body text,
// then random well-formed lines and one stream-ending case, all checked by a line decoder
// kept in step with the block. Depends on b64ld_pkg and base64_line_decoder_core.
module base64_line_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The run stops with a failure if it is still going after this many cycles.
	localparam int CYCLE_LIMIT  = 100000;
	// The tail wait, in cycles; it covers a full line check with margin.
	localparam int DRAIN_CYCLES = 250;
	// The long receiver hold-off, in cycles.
	localparam int HOLD_CYCLES  = 400;
	// Random lines are sent until this many transactions have been accepted.
	localparam int RANDOM_UNTIL = 200;

	// A directed row whose results come from the decoder below, not from the table.
	localparam int PREDICT = -1;

	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_8     = 8'h38;

	typedef struct packed {
		logic [7:0]       data;
		b64ld_pkg::kind_t kind;
		logic             last;
	} decoded_t;

	// One row of the directed table: a body character and, where it is plain to see,
	// the number of decoded bytes it releases, all of the same value.
	typedef struct packed {
		logic [7:0] ch;
		int         typed_n;
		logic [7:0] typed_val;
	} text_row_t;

	localparam int ROWS = 24;

	// All-zero and all-one quads, a CR before the newline, both padding forms, and a zero
	// byte that hides the rest of its line (including bytes with the top bit set).
	text_row_t dir_rows [ROWS] = '{
		'{CH_A, PREDICT, 8'h00}, '{CH_A, PREDICT, 8'h00},
		'{CH_A, PREDICT, 8'h00}, '{CH_A, PREDICT, 8'h00},
		'{b64ld_pkg::ASCII_NL, 3, 8'h00},
		'{CH_SLASH, PREDICT, 8'h00}, '{CH_SLASH, PREDICT, 8'h00},
		'{CH_SLASH, PREDICT, 8'h00}, '{CH_SLASH, PREDICT, 8'h00},
		'{b64ld_pkg::ASCII_CR, PREDICT, 8'h00},
		'{b64ld_pkg::ASCII_NL, 3, 8'hFF},
		'{CH_A, PREDICT, 8'h00}, '{CH_A, PREDICT, 8'h00},
		'{b64ld_pkg::ASCII_PAD, PREDICT, 8'h00},
		'{b64ld_pkg::ASCII_PAD, PREDICT, 8'h00},
		'{b64ld_pkg::ASCII_NL, 1, 8'h00},
		'{CH_LZ, PREDICT, 8'h00}, '{CH_LZ, PREDICT, 8'h00},
		'{CH_8, PREDICT, 8'h00}, '{b64ld_pkg::ASCII_PAD, PREDICT, 8'h00},
		'{b64ld_pkg::ASCII_NUL, PREDICT, 8'h00}, '{8'hFF, PREDICT, 8'h00},
		'{8'h80, PREDICT, 8'h00},
		'{b64ld_pkg::ASCII_NL, PREDICT, 8'h00}
	};

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] text_byte    = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] data_byte;
	logic [1:0] kind;
	logic       last;

	base64_line_decoder_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.kind         (kind),
		.last         (last)
	);

	// Decoded bytes and stream status that the block still owes, oldest first.
	decoded_t decoded_q[$];
	// Body characters of the line that is about to be sent.
	logic [7:0] tx_q[$];

	// The line decoder's own state, starting from its reset values.
	logic [7:0]                  ln_chars [b64ld_pkg::LINE_CHARS];
	logic [b64ld_pkg::CNT_W-1:0] ln_count    = '0;
	logic                        ln_over     = 1'b0;
	logic                        cr_held     = 1'b0;
	logic                        nul_seen    = 1'b0;
	logic                        stream_done = 1'b0;

	int    mismatches  = 0;
	int    items_in    = 0;
	int    results_out = 0;
	int    lines_sent  = 0;
	int    cycle_count = 0;
	int    hold_left   = 0;
	logic  hold_req    = 1'b0;
	// While calm is set, neither side idles.
	logic  calm        = 1'b0;
	string end_case    = "none";
	decoded_t head;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Value of one base64 alphabet character, or -1 when the character is not in it.
	function automatic int quad_value(input logic [7:0] ch);
		if (ch >= 8'h41 && ch <= 8'h5A)
			return int'(ch) - 8'h41;
		if (ch >= 8'h61 && ch <= 8'h7A)
			return int'(ch) - 8'h61 + 26;
		if (ch >= 8'h30 && ch <= 8'h39)
			return int'(ch) - 8'h30 + 52;
		if (ch == 8'h2B)
			return 62;
		if (ch == 8'h2F)
			return 63;
		return -1;
	endfunction

	// Alphabet character for a six-bit value; used to build encoded text.
	function automatic logic [7:0] b64_char(input int v);
		if (v < 26)
			return 8'(8'h41 + v);
		if (v < 52)
			return 8'(8'h61 + v - 26);
		if (v < 62)
			return 8'(8'h30 + v - 52);
		return (v == 62) ? 8'h2B : 8'h2F;
	endfunction

	function automatic logic [7:0] rand_char();
		return b64_char($urandom_range(0, 63));
	endfunction

	// Any byte but a newline; used where the block must ignore what it gets.
	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == b64ld_pkg::ASCII_NL);
		return c;
	endfunction

	function automatic void add_result(input b64ld_pkg::kind_t k, input logic [7:0] d);
		decoded_t r;
		r.data = (k == b64ld_pkg::KIND_DATA) ? d : 8'h00;
		r.kind = k;
		r.last = 1'b0;
		decoded_q.push_back(r);
	endfunction

	function automatic void clear_line();
		ln_count = '0;
		ln_over  = 1'b0;
		cr_held  = 1'b0;
		nul_seen = 1'b0;
	endfunction

	function automatic void store_char(input logic [7:0] ch);
		if (ln_count < b64ld_pkg::LINE_CHARS) begin
			ln_chars[ln_count] = ch;
			ln_count++;
		end else begin
			ln_over = 1'b1;
		end
	endfunction

	// Checks and decodes the held line: 0 when decoding goes on, 1 at the terminator line,
	// 2 at a format error. Quads are emitted in order until the first bad one.
	function automatic int line_check();
		int len;
		int a, b, c, d;
		len = ln_count;
		if (!ln_over && len == 4
		    && ln_chars[0] == b64ld_pkg::ASCII_PAD && ln_chars[1] == b64ld_pkg::ASCII_PAD
		    && ln_chars[2] == b64ld_pkg::ASCII_PAD && ln_chars[3] == b64ld_pkg::ASCII_PAD)
		begin
			add_result(b64ld_pkg::KIND_DONE, 8'h00);
			return 1;
		end
		if (ln_over || len == 0 || len % 4 != 0) begin
			add_result(b64ld_pkg::KIND_ERROR, 8'h00);
			return 2;
		end
		for (int q = 0; q + 4 <= len; q += 4) begin
			a = quad_value(ln_chars[q]);
			b = quad_value(ln_chars[q + 1]);
			c = (ln_chars[q + 2] == b64ld_pkg::ASCII_PAD) ? -2 : quad_value(ln_chars[q + 2]);
			d = (ln_chars[q + 3] == b64ld_pkg::ASCII_PAD) ? -2 : quad_value(ln_chars[q + 3]);
			// Padding must close the quad, drop only zero bits, and sit in the last quad.
			if (a < 0 || b < 0 || c == -1 || d == -1 || (c == -2 && d != -2)
			    || (c == -2 && b % 16 != 0) || (d == -2 && c >= 0 && c % 4 != 0)
			    || ((c == -2 || d == -2) && q + 4 != len)) begin
				add_result(b64ld_pkg::KIND_ERROR, 8'h00);
				return 2;
			end
			add_result(b64ld_pkg::KIND_DATA, 8'((a << 2) | (b >> 4)));
			if (c >= 0) begin
				add_result(b64ld_pkg::KIND_DATA, 8'((b << 4) | (c >> 2)));
				if (d >= 0)
					add_result(b64ld_pkg::KIND_DATA, 8'((c << 6) | d));
			end
		end
		return 0;
	endfunction

	// Advances the line decoder by one accepted transaction and queues what it releases.
	function automatic void decode_step(input logic [7:0] ch, input logic eoi);
		int       st;
		int       base;
		decoded_t r;
		if (stream_done)
			return;
		base = decoded_q.size();
		if (eoi) begin
			// A partial line is judged first; a trailing CR is simply dropped.
			if (ln_count != 0 || ln_over || cr_held || nul_seen) begin
				st = line_check();
				if (st == 0)
					add_result(b64ld_pkg::KIND_ERROR, 8'h00);
			end else begin
				add_result(b64ld_pkg::KIND_ERROR, 8'h00);
			end
			stream_done = 1'b1;
			clear_line();
		end else if (ch == b64ld_pkg::ASCII_NL) begin
			st = line_check();
			clear_line();
			if (st != 0)
				stream_done = 1'b1;
		end else if (!nul_seen) begin
			// A held CR that is not followed by the newline becomes line content.
			if (cr_held) begin
				cr_held = 1'b0;
				store_char(b64ld_pkg::ASCII_CR);
			end
			if (ch == b64ld_pkg::ASCII_CR)
				cr_held = 1'b1;
			else if (ch == b64ld_pkg::ASCII_NUL)
				nul_seen = 1'b1;
			else
				store_char(ch);
		end
		if (decoded_q.size() > base) begin
			r = decoded_q.pop_back();
			r.last = 1'b1;
			decoded_q.push_back(r);
		end
	endfunction

	// Offers one transaction and waits for it to be taken. It starts and ends at a falling
	// edge, so the valid line is written once per step and never dropped between two
	// back-to-back transactions. A table row with typed_n of zero or more replaces what
	// the decoder queued with the typed bytes.
	task automatic offer(input logic [7:0] ch, input logic eoi, input int typed_n,
	                     input logic [7:0] typed_val);
		decoded_t r;
		int       base;
		while (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		text_byte    <= ch;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_in++;
		base = decoded_q.size();
		decode_step(ch, eoi);
		if (typed_n >= 0) begin
			while (decoded_q.size() > base)
				r = decoded_q.pop_back();
			for (int i = 0; i < typed_n; i++) begin
				r.data = typed_val;
				r.kind = b64ld_pkg::KIND_DATA;
				r.last = (i == typed_n - 1);
				decoded_q.push_back(r);
			end
		end
		@(negedge clk);
	endtask

	task automatic send_tx();
		logic [7:0] ch;
		while (tx_q.size() != 0) begin
			ch = tx_q.pop_front();
			offer(ch, 1'b0, PREDICT, 8'h00);
		end
	endtask

	// Builds one well-formed line of the given number of quads with random content: the
	// last quad may carry one or two pad characters with zero dropped bits, and the line
	// may end with a zero byte and ignored junk, and with a CR before the newline.
	task automatic put_line(input int quads, input logic with_nl);
		int pad;
		for (int i = 0; i < 4 * (quads - 1); i++)
			tx_q.push_back(rand_char());
		pad = $urandom_range(0, 2);
		tx_q.push_back(rand_char());
		if (pad == 2) begin
			tx_q.push_back(b64_char($urandom_range(0, 3) * 16));
			tx_q.push_back(b64ld_pkg::ASCII_PAD);
			tx_q.push_back(b64ld_pkg::ASCII_PAD);
		end else if (pad == 1) begin
			tx_q.push_back(rand_char());
			tx_q.push_back(b64_char($urandom_range(0, 15) * 4));
			tx_q.push_back(b64ld_pkg::ASCII_PAD);
		end else begin
			repeat (3) tx_q.push_back(rand_char());
		end
		if ($urandom_range(0, 4) == 0) begin
			tx_q.push_back(b64ld_pkg::ASCII_NUL);
			repeat ($urandom_range(0, 3)) tx_q.push_back(noise_char());
		end
		if ($urandom_range(0, 2) == 0)
			tx_q.push_back(b64ld_pkg::ASCII_CR);
		if (with_nl)
			tx_q.push_back(b64ld_pkg::ASCII_NL);
	endtask

	// Ends the stream through one case picked at random, then offers a few more
	// transactions that the halted block must drop without a result.
	task automatic end_stream();
		int         sel;
		int         n;
		int         v;
		logic [7:0] bad;
		sel = $urandom_range(0, 10);
		case (sel)
			0: begin
				end_case = "terminator line";
				repeat (4) tx_q.push_back(b64ld_pkg::ASCII_PAD);
				if ($urandom_range(0, 1) == 1)
					tx_q.push_back(b64ld_pkg::ASCII_CR);
				tx_q.push_back(b64ld_pkg::ASCII_NL);
			end
			1: begin
				end_case = "terminator cut off by end of input";
				repeat (4) tx_q.push_back(b64ld_pkg::ASCII_PAD);
			end
			2: begin
				end_case = "end of input between lines";
			end
			3: begin
				end_case = "good line cut off by end of input";
				put_line($urandom_range(1, 19), 1'b0);
			end
			4: begin
				end_case = "character outside the alphabet";
				n = 4 * $urandom_range(1, 6);
				repeat (n) tx_q.push_back(rand_char());
				do begin
					bad = 8'($urandom_range(0, 255));
				end while (quad_value(bad) >= 0 || bad == b64ld_pkg::ASCII_PAD
				           || bad == b64ld_pkg::ASCII_NUL || bad == b64ld_pkg::ASCII_NL
				           || bad == b64ld_pkg::ASCII_CR);
				tx_q[$urandom_range(0, n - 1)] = bad;
				tx_q.push_back(b64ld_pkg::ASCII_NL);
			end
			5: begin
				end_case = "line length not a multiple of four";
				n = ($urandom_range(0, 3) == 0) ? 0
				    : $urandom_range(0, 18) * 4 + $urandom_range(1, 3);
				repeat (n) tx_q.push_back(rand_char());
				tx_q.push_back(b64ld_pkg::ASCII_NL);
			end
			6: begin
				end_case = "nonzero padding bits";
				repeat (4 * $urandom_range(0, 4)) tx_q.push_back(rand_char());
				tx_q.push_back(rand_char());
				v = $urandom_range(0, 63);
				if ($urandom_range(0, 1) == 1) begin
					if (v % 16 == 0)
						v++;
					tx_q.push_back(b64_char(v));
					tx_q.push_back(b64ld_pkg::ASCII_PAD);
				end else begin
					if (v % 4 == 0)
						v++;
					tx_q.push_back(rand_char());
					tx_q.push_back(b64_char(v));
				end
				tx_q.push_back(b64ld_pkg::ASCII_PAD);
				tx_q.push_back(b64ld_pkg::ASCII_NL);
			end
			7: begin
				end_case = "padding before the last quad";
				tx_q.push_back(rand_char());
				tx_q.push_back(b64_char($urandom_range(0, 3) * 16));
				tx_q.push_back(b64ld_pkg::ASCII_PAD);
				tx_q.push_back(b64ld_pkg::ASCII_PAD);
				repeat (4) tx_q.push_back(rand_char());
				tx_q.push_back(b64ld_pkg::ASCII_NL);
			end
			8: begin
				end_case = "overlong line";
				repeat ($urandom_range(b64ld_pkg::LINE_CHARS + 1, b64ld_pkg::LINE_CHARS + 8))
					tx_q.push_back(rand_char());
				tx_q.push_back(b64ld_pkg::ASCII_NL);
			end
			9: begin
				end_case = "carriage return inside a line";
				repeat (4) tx_q.push_back(rand_char());
				tx_q.push_back(b64ld_pkg::ASCII_CR);
				repeat (3) tx_q.push_back(rand_char());
				tx_q.push_back(b64ld_pkg::ASCII_NL);
			end
			default: begin
				end_case = "pad character out of place";
				if ($urandom_range(0, 1) == 1) begin
					tx_q.push_back(b64ld_pkg::ASCII_PAD);
					repeat (3) tx_q.push_back(rand_char());
				end else begin
					repeat (2) tx_q.push_back(rand_char());
					tx_q.push_back(b64ld_pkg::ASCII_PAD);
					tx_q.push_back(rand_char());
				end
				tx_q.push_back(b64ld_pkg::ASCII_NL);
			end
		endcase
		send_tx();
		if (sel >= 1 && sel <= 3)
			offer(8'($urandom_range(0, 255)), 1'b1, PREDICT, 8'h00);
		lines_sent++;
		// The halted block takes these and must say nothing; one of them always carries
		// end of input.
		for (int i = 0; i < 8; i++)
			offer(8'($urandom_range(0, 255)), (i == 3) || ($urandom_range(0, 3) == 0),
			      PREDICT, 8'h00);
	endtask

	// Receiver side: stalls at random, except in the calm stretch, and once holds off for
	// a long count of cycles so that the block backs up into its input.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 14);
			end
		end
	end

	// Every result transaction is matched against the oldest one still owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_out++;
			if (decoded_q.size() == 0) begin
				flag_mismatch($sformatf("result with nothing owed: data %02h kind %0d last %0b",
				                        data_byte, kind, last));
			end else begin
				head = decoded_q.pop_front();
				if (data_byte !== head.data || kind !== head.kind || last !== head.last)
					flag_mismatch($sformatf(
						"result %0d: got %02h/%0d/%0b, owed %02h/%0d/%0b",
						results_out, data_byte, kind, last, head.data, head.kind, head.last));
			end
		end
	end

	// Watchdog: a hung block or a lost result ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		// Reset is held from time zero and released at a falling edge.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table.
		for (int i = 0; i < ROWS; i++)
			offer(dir_rows[i].ch, 1'b0, dir_rows[i].typed_n, dir_rows[i].typed_val);
		lines_sent = 4;

		// The sender goes quiet until every owed result has come out.
		in_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(negedge clk);

		// Random well-formed lines. The first is a full 76-character line sent while the
		// receiver holds off, so the output register fills and the input stalls. A few
		// lines further on, both sides run without idling.
		hold_req = 1'b1;
		for (int n = 0; items_in < RANDOM_UNTIL; n++) begin
			calm = (n >= 4 && n < 7);
			put_line((n == 0 || $urandom_range(0, 9) == 0) ? 19 : $urandom_range(1, 5), 1'b1);
			send_tx();
			lines_sent++;
		end
		calm = 1'b0;

		end_stream();

		in_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run took %0d input transactions over %0d lines and checked %0d results.",
		         items_in, lines_sent, results_out);
		$display("The stream ended on a %s; %0d mismatches.", end_case, mismatches);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/b64ld_pkg.sv
sv/base64_line_decoder_core.sv
tb/sv/base64_line_decoder_core_tb.sv
